// ----- hw/rtl/sia_pkg.sv -----
// ----------------------------------------------------------------------------
// sia_pkg
// Shared widths, opcodes, step codes and word types for the signed ALU.
// ----------------------------------------------------------------------------
package sia_pkg;

  localparam int DATA_WIDTH = 24;
  localparam int CNT_W      = $clog2(DATA_WIDTH);
  localparam int STEP_W     = 3;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  localparam logic [STEP_W-1:0] STEP_HOLD = 3'd0;
  localparam logic [STEP_W-1:0] STEP_LOAD = 3'd1;
  localparam logic [STEP_W-1:0] STEP_ALU  = 3'd2;
  localparam logic [STEP_W-1:0] STEP_NEGA = 3'd3;
  localparam logic [STEP_W-1:0] STEP_NEGB = 3'd4;
  localparam logic [STEP_W-1:0] STEP_MUL  = 3'd5;
  localparam logic [STEP_W-1:0] STEP_DIV  = 3'd6;
  localparam logic [STEP_W-1:0] STEP_FIX  = 3'd7;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] operand_a;
    logic signed [DATA_WIDTH-1:0] operand_b;
    logic [1:0]                   opcode;
  } in_word_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] result;
    logic                         div_by_zero;
  } out_word_t;

  typedef struct packed {
    logic              sub;
    logic [STEP_W-1:0] step;
  } ctrl_t;

endpackage

// ----- hw/rtl/sia_addsub.sv -----
// ----------------------------------------------------------------------------
// sia_addsub
// Shared add/subtract unit, one bit wider than the data path.
// ----------------------------------------------------------------------------
module sia_addsub (
  input  logic [sia_pkg::DATA_WIDTH:0] x,
  input  logic [sia_pkg::DATA_WIDTH:0] y,
  input  logic                         sub,
  output logic [sia_pkg::DATA_WIDTH:0] sum
);

  assign sum = x + (y ^ {(sia_pkg::DATA_WIDTH+1){sub}})
             + {{sia_pkg::DATA_WIDTH{1'b0}}, sub};

endmodule

// ----- hw/rtl/sia_dpath.sv -----
// ----------------------------------------------------------------------------
// sia_dpath
// Operand, accumulator and shift registers around the shared adder; one
// step per cycle for add, subtract, shift-add multiply and restoring divide.
// ----------------------------------------------------------------------------
module sia_dpath (
  input  logic                          clk,
  input  sia_pkg::ctrl_t                ctrl,
  input  sia_pkg::in_word_t             in_word,
  output logic [sia_pkg::DATA_WIDTH-1:0] result
);

  localparam int W = sia_pkg::DATA_WIDTH;

  logic [W:0]   acc_r, acc_nxt;
  logic [W-1:0] mq_r, mq_nxt;
  logic [W-1:0] md_r, md_nxt;
  logic         neg_r, neg_nxt;

  logic [W:0]   add_x, add_y, add_sum;
  logic         add_sub;

  sia_addsub u_addsub (
    .x   (add_x),
    .y   (add_y),
    .sub (add_sub),
    .sum (add_sum)
  );

  always_comb begin
    add_x   = '0;
    add_y   = {1'b0, md_r};
    add_sub = 1'b0;
    acc_nxt = acc_r;
    mq_nxt  = mq_r;
    md_nxt  = md_r;
    neg_nxt = neg_r;
    unique case (ctrl.step)
      sia_pkg::STEP_LOAD: begin
        acc_nxt = '0;
        mq_nxt  = in_word.operand_a;
        md_nxt  = in_word.operand_b;
        neg_nxt = in_word.operand_a[W-1] ^ in_word.operand_b[W-1];
      end
      sia_pkg::STEP_ALU: begin
        add_x   = {1'b0, mq_r};
        add_sub = ctrl.sub;
        acc_nxt = add_sum;
      end
      sia_pkg::STEP_NEGA: begin
        add_y   = {1'b0, mq_r};
        add_sub = 1'b1;
        if (mq_r[W-1]) begin
          mq_nxt = add_sum[W-1:0];
        end
      end
      sia_pkg::STEP_NEGB: begin
        add_sub = 1'b1;
        if (md_r[W-1]) begin
          md_nxt = add_sum[W-1:0];
        end
      end
      sia_pkg::STEP_MUL: begin
        add_x  = acc_r;
        if (mq_r[0]) begin
          acc_nxt = add_sum;
        end
        mq_nxt = {1'b0, mq_r[W-1:1]};
        md_nxt = {md_r[W-2:0], 1'b0};
      end
      sia_pkg::STEP_DIV: begin
        add_x   = {acc_r[W-1:0], mq_r[W-1]};
        add_sub = 1'b1;
        acc_nxt = add_sum[W] ? add_x : add_sum;
        mq_nxt  = {mq_r[W-2:0], ~add_sum[W]};
      end
      sia_pkg::STEP_FIX: begin
        add_y   = {1'b0, mq_r};
        add_sub = neg_r;
        acc_nxt = add_sum;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    mq_r  <= mq_nxt;
    md_r  <= md_nxt;
    neg_r <= neg_nxt;
  end

  assign result = acc_r[W-1:0];

endmodule

// ----- hw/rtl/signed_int24_alu_unit.sv -----
// ----------------------------------------------------------------------------
// signed_int24_alu_unit
// Signed 24-bit ALU: add, subtract, multiply (low bits) and divide toward zero.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low. Its result appears on
// out_word for exactly one cycle with out_valid high and cannot be held off.
// All work runs through one shared adder under a small sequencer: add and
// subtract take one ALU step, multiply one shift-add per operand bit, divide
// two magnitude steps, one restoring step per quotient bit and one sign fix;
// a divide by zero gives out_valid in the cycle after acceptance. busy is low
// in the cycle out_valid is high, so the next word may be taken in that same
// cycle.
module signed_int24_alu_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  sia_pkg::in_word_t  in_word,
  output logic               out_valid,
  output sia_pkg::out_word_t out_word
);

  localparam int W      = sia_pkg::DATA_WIDTH;
  localparam int CNT_W  = sia_pkg::CNT_W;
  localparam int ST_W   = 3;

  localparam logic [ST_W-1:0] S_IDLE = 3'd0;
  localparam logic [ST_W-1:0] S_ALU  = 3'd1;
  localparam logic [ST_W-1:0] S_NEGA = 3'd2;
  localparam logic [ST_W-1:0] S_NEGB = 3'd3;
  localparam logic [ST_W-1:0] S_MUL  = 3'd4;
  localparam logic [ST_W-1:0] S_DIV  = 3'd5;
  localparam logic [ST_W-1:0] S_FIX  = 3'd6;
  localparam logic [ST_W-1:0] S_OUT  = 3'd7;

  logic [ST_W-1:0]  state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]       op_r, op_nxt;
  logic             dz_r, dz_nxt;
  logic             accept, cnt_last, b_zero;
  logic [W-1:0]     dp_result;
  sia_pkg::ctrl_t   ctrl;

  assign busy     = (state_r != S_IDLE) && (state_r != S_OUT);
  assign accept   = start && !busy;
  assign cnt_last = (cnt_r == CNT_W'(W-1));
  assign b_zero   = (in_word.operand_b == '0);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    op_nxt    = op_r;
    dz_nxt    = dz_r;
    ctrl.sub  = (op_r == sia_pkg::OP_SUB);
    ctrl.step = sia_pkg::STEP_HOLD;
    unique case (state_r) inside
      S_IDLE, S_OUT: begin
        state_nxt = S_IDLE;
        if (accept) begin
          ctrl.step = sia_pkg::STEP_LOAD;
          op_nxt    = in_word.opcode;
          dz_nxt    = 1'b0;
          cnt_nxt   = '0;
          unique case (in_word.opcode) inside
            sia_pkg::OP_ADD, sia_pkg::OP_SUB: state_nxt = S_ALU;
            sia_pkg::OP_MUL:                  state_nxt = S_MUL;
            default: begin
              if (b_zero) begin
                dz_nxt    = 1'b1;
                state_nxt = S_OUT;
              end else begin
                state_nxt = S_NEGA;
              end
            end
          endcase
        end
      end
      S_ALU: begin
        ctrl.step = sia_pkg::STEP_ALU;
        state_nxt = S_OUT;
      end
      S_NEGA: begin
        ctrl.step = sia_pkg::STEP_NEGA;
        state_nxt = S_NEGB;
      end
      S_NEGB: begin
        ctrl.step = sia_pkg::STEP_NEGB;
        state_nxt = S_DIV;
      end
      S_MUL: begin
        ctrl.step = sia_pkg::STEP_MUL;
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_last) begin
          state_nxt = S_OUT;
        end
      end
      S_DIV: begin
        ctrl.step = sia_pkg::STEP_DIV;
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_last) begin
          state_nxt = S_FIX;
        end
      end
      S_FIX: begin
        ctrl.step = sia_pkg::STEP_FIX;
        state_nxt = S_OUT;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
    op_r <= op_nxt;
    dz_r <= dz_nxt;
  end

  sia_dpath u_dpath (
    .clk     (clk),
    .ctrl    (ctrl),
    .in_word (in_word),
    .result  (dp_result)
  );

  assign out_valid            = (state_r == S_OUT);
  assign out_word.result      = dp_result;
  assign out_word.div_by_zero = dz_r;

  a_valid_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.div_by_zero) |-> (out_word.result == '0))
    else $error("divide by zero result not zero");

  a_dz_fast: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_word.opcode == sia_pkg::OP_DIV) && b_zero)
      |=> (out_valid && out_word.div_by_zero))
    else $error("divide by zero not reported next cycle");

  a_add_lat: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && ((in_word.opcode == sia_pkg::OP_ADD) ||
                (in_word.opcode == sia_pkg::OP_SUB)))
      |-> ##2 (out_valid && !out_word.div_by_zero))
    else $error("add/subtract result late");

endmodule

// ----- verif/signed_int24_alu_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int24_alu_unit_test
// Self-checking bench for the signed 24-bit ALU: a short table of edge cases
// (wraparound, most-negative operands, divide by zero), then random words
// with random issue gaps; results checked against table or in-bench model.
// ----------------------------------------------------------------------------
module signed_int24_alu_unit_test;

  localparam int DW         = sia_pkg::DATA_WIDTH;
  localparam int IN_W       = $bits(sia_pkg::in_word_t);
  localparam int NUM_ROWS   = 25;
  localparam int NUM_RANDOM = 1650;

  typedef struct packed {
    logic [DW-1:0] a;
    logic [DW-1:0] b;
    logic [1:0]    op;
    logic          known;
    logic [DW-1:0] res;
    logic          dz;
  } stim_row_t;

  stim_row_t directed_rows [NUM_ROWS] = '{
    '{24'h000000, 24'h000000, sia_pkg::OP_ADD, 1'b1, 24'h000000, 1'b0},
    '{24'h7FFFFF, 24'h000001, sia_pkg::OP_ADD, 1'b1, 24'h800000, 1'b0},
    '{24'h800000, 24'hFFFFFF, sia_pkg::OP_ADD, 1'b1, 24'h7FFFFF, 1'b0},
    '{24'h800000, 24'h000001, sia_pkg::OP_SUB, 1'b1, 24'h7FFFFF, 1'b0},
    '{24'h7FFFFF, 24'hFFFFFF, sia_pkg::OP_SUB, 1'b1, 24'h800000, 1'b0},
    '{24'h000000, 24'h800000, sia_pkg::OP_SUB, 1'b1, 24'h800000, 1'b0},
    '{24'hFFFFFF, 24'h7FFFFF, sia_pkg::OP_SUB, 1'b1, 24'h800000, 1'b0},
    '{24'h7FFFFF, 24'h7FFFFF, sia_pkg::OP_MUL, 1'b1, 24'h000001, 1'b0},
    '{24'h800000, 24'h800000, sia_pkg::OP_MUL, 1'b1, 24'h000000, 1'b0},
    '{24'h800000, 24'hFFFFFF, sia_pkg::OP_MUL, 1'b1, 24'h800000, 1'b0},
    '{24'hFFFFFF, 24'hFFFFFF, sia_pkg::OP_MUL, 1'b1, 24'h000001, 1'b0},
    '{24'h123456, 24'h000000, sia_pkg::OP_DIV, 1'b1, 24'h000000, 1'b1},
    '{24'h000000, 24'h000000, sia_pkg::OP_DIV, 1'b1, 24'h000000, 1'b1},
    '{24'h800000, 24'h000000, sia_pkg::OP_DIV, 1'b1, 24'h000000, 1'b1},
    '{24'h800000, 24'hFFFFFF, sia_pkg::OP_DIV, 1'b1, 24'h800000, 1'b0},
    '{24'h800000, 24'h800000, sia_pkg::OP_DIV, 1'b1, 24'h000001, 1'b0},
    '{24'h7FFFFF, 24'h800000, sia_pkg::OP_DIV, 1'b1, 24'h000000, 1'b0},
    '{24'h800000, 24'h7FFFFF, sia_pkg::OP_DIV, 1'b1, 24'hFFFFFF, 1'b0},
    '{24'h7FFFFF, 24'h000001, sia_pkg::OP_DIV, 1'b1, 24'h7FFFFF, 1'b0},
    '{24'h000005, 24'h000007, sia_pkg::OP_DIV, 1'b1, 24'h000000, 1'b0},
    '{24'hFFFFF9, 24'h000002, sia_pkg::OP_DIV, 1'b0, 24'h000000, 1'b0},
    '{24'h000007, 24'hFFFFFE, sia_pkg::OP_DIV, 1'b0, 24'h000000, 1'b0},
    '{24'hFFFFF9, 24'hFFFFFE, sia_pkg::OP_DIV, 1'b0, 24'h000000, 1'b0},
    '{24'hABCDEF, 24'h123456, sia_pkg::OP_MUL, 1'b0, 24'h000000, 1'b0},
    '{24'h555555, 24'hAAAAAA, sia_pkg::OP_ADD, 1'b0, 24'h000000, 1'b0}
  };

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  sia_pkg::in_word_t  in_word = '0;
  logic               out_valid;
  sia_pkg::out_word_t out_word;

  sia_pkg::out_word_t pending_results[$];
  int                 error_count = 0;
  int                 checked_count = 0;
  int                 op_count[4] = '{0, 0, 0, 0};
  int                 zero_div_count = 0;
  bit                 dense_mode = 1'b0;

  signed_int24_alu_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_word (out_word)
  );

  always #1 clk = ~clk;

  function automatic sia_pkg::out_word_t alu_outcome(input sia_pkg::in_word_t w);
    logic [DW-1:0]      a, b, mag_a, mag_b, quo;
    sia_pkg::out_word_t o;
    a = w.operand_a;
    b = w.operand_b;
    o.result = '0;
    o.div_by_zero = 1'b0;
    case (w.opcode)
      sia_pkg::OP_ADD: o.result = a + b;
      sia_pkg::OP_SUB: o.result = a - b;
      sia_pkg::OP_MUL: o.result = a * b;
      default: begin
        if (b == '0) begin
          o.div_by_zero = 1'b1;
        end else begin
          mag_a = a[DW-1] ? -a : a;
          mag_b = b[DW-1] ? -b : b;
          quo = mag_a / mag_b;
          o.result = (a[DW-1] ^ b[DW-1]) ? -quo : quo;
        end
      end
    endcase
    return o;
  endfunction

  function automatic logic [DW-1:0] pick_operand();
    logic [DW-1:0] v;
    case ($urandom_range(0, 9)) inside
      0: begin
        case ($urandom_range(0, 4))
          0: v = '0;
          1: v = 24'h000001;
          2: v = 24'hFFFFFF;
          3: v = 24'h7FFFFF;
          default: v = 24'h800000;
        endcase
      end
      1, 2: v = DW'($signed($urandom_range(0, 128)) - 64);
      3: v = DW'(1) << $urandom_range(0, DW - 1);
      4: v = -(DW'(1) << $urandom_range(0, DW - 1));
      default: v = DW'($urandom);
    endcase
    return v;
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (dense_mode || roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 20);
    return $urandom_range(30, 80);
  endfunction

  task automatic issue_word(input sia_pkg::in_word_t w,
                            input sia_pkg::out_word_t want, input int gap);
    start <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (busy);
    pending_results.push_back(want);
    op_count[w.opcode]++;
    if (want.div_by_zero) zero_div_count++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) begin
        in_word <= IN_W'({$urandom, $urandom});
        @(posedge clk);
      end
    end
  endtask

  always @(posedge clk) begin
    sia_pkg::out_word_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h/%b", $time, out_word.result,
                 out_word.div_by_zero);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        checked_count++;
        if (out_word.result !== want.result) begin
          $display("%0t: result expected %h got %h", $time, want.result,
                   out_word.result);
          error_count++;
        end
        if (out_word.div_by_zero !== want.div_by_zero) begin
          $display("%0t: div_by_zero expected %b got %b", $time,
                   want.div_by_zero, out_word.div_by_zero);
          error_count++;
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    sia_pkg::in_word_t  w;
    sia_pkg::out_word_t want;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < NUM_ROWS; i++) begin
      w.operand_a = directed_rows[i].a;
      w.operand_b = directed_rows[i].b;
      w.opcode = directed_rows[i].op;
      if (directed_rows[i].known) begin
        want.result = directed_rows[i].res;
        want.div_by_zero = directed_rows[i].dz;
      end else begin
        want = alu_outcome(w);
      end
      issue_word(w, want, pick_gap());
    end

    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i % 100 == 0) dense_mode = ($urandom_range(0, 3) == 0);
      w.operand_a = pick_operand();
      w.operand_b = pick_operand();
      w.opcode = 2'($urandom_range(0, 3));
      if (w.opcode == sia_pkg::OP_DIV && $urandom_range(0, 9) == 0) w.operand_b = '0;
      issue_word(w, alu_outcome(w), pick_gap());
    end
    start <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Issued %0d add, %0d sub, %0d mul, %0d div words (%0d divide by zero).",
             op_count[sia_pkg::OP_ADD], op_count[sia_pkg::OP_SUB],
             op_count[sia_pkg::OP_MUL], op_count[sia_pkg::OP_DIV], zero_div_count);
    $display("Checked %0d results, %0d mismatches.", checked_count, error_count);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
